### rtl/core/mva_pkg.sv
// Shared types and constants for the MIDI voice allocator.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps

package mva_pkg;

  // Sizing of the voice pool and the channel range.
  localparam int VOICES   = 16;
  localparam int CHANNELS = 16;

  localparam int IDX_W    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CNT_W    = $clog2(VOICES + 1);
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int CHAN_W   = 5;
  localparam int KEY_W    = 7;
  localparam int NOTE_W   = 8;
  localparam int VEL_W    = 15;
  localparam int PITCH_W  = 16;
  localparam int AGE_W    = 32;
  localparam int SLOT_W   = 5;
  localparam int IN_W     = 32;
  localparam int OUT_W    = 56;

  localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(VOICES - 1);
  localparam logic [CHAN_W-1:0] CHAN_MAX   = CHAN_W'(CHANNELS);
  localparam logic [CHAN_W-1:0] CHAN_MIN   = CHAN_W'(1);
  localparam logic [NOTE_W-1:0] NOTE_NONE  = '1;
  localparam logic [SLOT_W-1:0] SLOT_NONE  = '1;
  localparam logic [AGE_W-1:0]  AGE_MAX    = '1;
  localparam logic [AGE_W-1:0]  AGE_FIRST  = AGE_W'(1);

  // Event codes carried in the operation field.
  typedef enum logic [1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_PITCH    = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } st_t;

  // One voice entry as stored in the voice table.
  typedef struct packed {
    logic              busy;
    logic [CHAN_W-1:0] chan;
    logic [KEY_W-1:0]  key;
    logic [AGE_W-1:0]  age;
  } voice_t;

  // Write request into the voice table.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    voice_t           ent;
  } voice_wr_t;

  // Outcome of one pass over the voice table.
  typedef struct packed {
    logic             done;
    logic             match_hit;
    logic [IDX_W-1:0] match_idx;
    logic             free_hit;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] old_idx;
  } scan_res_t;

endpackage

### rtl/core/mva_voice_table.sv
// Voice table: per-voice channel, key and age in a memory with a registered
// read port, busy flags and the active-voice count in flip-flops.
// Depends on mva_pkg.
`timescale 1ns / 1ps

module mva_voice_table
  import mva_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output voice_t           rd_data,
  input  voice_wr_t        wr,
  output logic [CNT_W-1:0] act_cnt
);

  logic [CHAN_W-1:0] chan_mem [VOICES];
  logic [KEY_W-1:0]  key_mem  [VOICES];
  logic [AGE_W-1:0]  age_mem  [VOICES];

  logic [VOICES-1:0] busy_r, busy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  voice_t            rd_data_r;

  // Busy flags and the running count of busy voices.
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (clr) begin
      busy_nxt = '0;
      cnt_nxt  = '0;
    end else if (wr.en) begin
      busy_nxt[wr.idx] = wr.ent.busy;
      if (wr.ent.busy && !busy_r[wr.idx]) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end else if (!wr.ent.busy && busy_r[wr.idx]) begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Entry storage: one write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      chan_mem[wr.idx] <= wr.ent.chan;
      key_mem[wr.idx]  <= wr.ent.key;
      age_mem[wr.idx]  <= wr.ent.age;
    end
  end

  // Registered read port used by the scanner.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r.busy <= busy_r[rd_addr];
      rd_data_r.chan <= chan_mem[rd_addr];
      rd_data_r.key  <= key_mem[rd_addr];
      rd_data_r.age  <= age_mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign act_cnt = cnt_r;

endmodule

### rtl/core/mva_voice_scan.sv
// Voice scanner: walks the voice table one entry per cycle through a single
// compare unit, finding the matching, the first free and the oldest voice.
// Depends on mva_pkg.
`timescale 1ns / 1ps

module mva_voice_scan
  import mva_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CHAN_W-1:0] ch,
  input  logic [KEY_W-1:0]  key,
  output logic              rd_en,
  output logic [IDX_W-1:0]  rd_addr,
  input  voice_t            rd_data,
  output scan_res_t         res
);

  logic             run_r, run_nxt;
  logic             chk_r, chk_nxt;
  logic             done_r, done_nxt;
  logic [IDX_W-1:0] addr_r, addr_nxt;
  logic [IDX_W-1:0] chk_idx_r;

  logic             match_hit_r, match_hit_nxt;
  logic [IDX_W-1:0] match_idx_r, match_idx_nxt;
  logic             free_hit_r, free_hit_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0] old_idx_r, old_idx_nxt;
  logic [AGE_W-1:0] old_age_r, old_age_nxt;

  logic is_match;
  logic is_older;

  // Address sequencer: issues one table read per cycle.
  always_comb begin
    run_nxt  = run_r;
    addr_nxt = addr_r;
    if (start) begin
      run_nxt  = 1'b1;
      addr_nxt = '0;
    end else if (run_r) begin
      if (addr_r == LAST_IDX) begin
        run_nxt = 1'b0;
      end else begin
        addr_nxt = addr_r + IDX_W'(1);
      end
    end
    chk_nxt  = run_r && !start;
    done_nxt = chk_r && (chk_idx_r == LAST_IDX);
  end

  // Shared compare unit: key match and strict age compare on the entry read.
  assign is_match = rd_data.busy && (rd_data.chan == ch) && (rd_data.key == key);
  assign is_older = rd_data.age < old_age_r;

  always_comb begin
    match_hit_nxt = match_hit_r;
    match_idx_nxt = match_idx_r;
    free_hit_nxt  = free_hit_r;
    free_idx_nxt  = free_idx_r;
    old_idx_nxt   = old_idx_r;
    old_age_nxt   = old_age_r;
    if (start) begin
      match_hit_nxt = 1'b0;
      free_hit_nxt  = 1'b0;
    end else if (chk_r) begin
      if (is_match && !match_hit_r) begin
        match_hit_nxt = 1'b1;
        match_idx_nxt = chk_idx_r;
      end
      if (!rd_data.busy && !free_hit_r) begin
        free_hit_nxt = 1'b1;
        free_idx_nxt = chk_idx_r;
      end
      // Ties keep the lower index since the compare is strict.
      if ((chk_idx_r == '0) || is_older) begin
        old_idx_nxt = chk_idx_r;
        old_age_nxt = rd_data.age;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      chk_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      chk_r  <= chk_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    chk_idx_r   <= addr_r;
    match_hit_r <= match_hit_nxt;
    match_idx_r <= match_idx_nxt;
    free_hit_r  <= free_hit_nxt;
    free_idx_r  <= free_idx_nxt;
    old_idx_r   <= old_idx_nxt;
    old_age_r   <= old_age_nxt;
  end

  assign rd_en   = run_r;
  assign rd_addr = addr_r;

  assign res.done      = done_r;
  assign res.match_hit = match_hit_r;
  assign res.match_idx = match_idx_r;
  assign res.free_hit  = free_hit_r;
  assign res.free_idx  = free_idx_r;
  assign res.old_idx   = old_idx_r;

endmodule

### rtl/core/midi_voice_allocator_core.sv
// MIDI voice allocator. A note-on or note-off request is answered after the voice
// scanner has read every table entry, one per cycle; pitch-wheel and clear go
// straight to commit. One request is in work at a time: a new one is taken only
// in the idle state, after the last has committed, so the next is taken while a
// result waits; a commit waits while an earlier result is unaccepted.
// Synchronous active-low reset; clear returns the voice pool, the pitch-wheel
// values and the note state to their reset values.
// Depends on mva_pkg, mva_voice_table and mva_voice_scan.
`timescale 1ns / 1ps

module midi_voice_allocator_core
  import mva_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // [1:0] operation, [6:2] channel, [13:7] note, [29:14] amount, [31:30] zero
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // [0] gate, [5:1] channel_now, [13:6] note_now, [28:14] velocity_now,
  // [44:29] pitch_now, [49:45] active_voices, [54:50] voice_slot, [55] zero
  output logic [OUT_W-1:0] out_tdata
);

  st_t st_r, st_nxt;

  // Request fields held for the duration of the work.
  op_t                 op_r;
  logic [CHAN_W-1:0]   ch_r;
  logic [KEY_W-1:0]    key_r;
  logic [VEL_W-1:0]    vel_r;
  logic signed [PITCH_W-1:0] amt_r;

  logic [CHAN_W-1:0]   in_ch_raw, in_ch;
  logic signed [PITCH_W-1:0] in_amt;
  logic [VEL_W-1:0]    in_vel;
  logic                accept;
  logic                commit;
  logic                scan_start;

  // Note state, which is also the output register.
  logic                      gate_r, gate_nxt;
  logic [CHAN_W-1:0]         cur_ch_r, cur_ch_nxt;
  logic [NOTE_W-1:0]         cur_note_r, cur_note_nxt;
  logic [VEL_W-1:0]          cur_vel_r, cur_vel_nxt;
  logic signed [PITCH_W-1:0] cur_pitch_r, cur_pitch_nxt;
  logic [SLOT_W-1:0]         slot_r, slot_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [AGE_W-1:0]          order_r, order_nxt;

  logic signed [PITCH_W-1:0] pitch_r [CHANNELS];
  logic [CH_IDX_W-1:0]       pitch_idx;
  logic signed [PITCH_W-1:0] ch_pitch;
  logic [CHAN_W-1:0]         ch_m1;

  logic             tbl_rd_en;
  logic [IDX_W-1:0] tbl_rd_addr;
  voice_t           tbl_rd_data;
  voice_wr_t        tbl_wr;
  logic             tbl_clr;
  logic [CNT_W-1:0] act_cnt;
  scan_res_t        scan_res;
  logic [IDX_W-1:0] on_idx;

  // Input decode: clamp channel and velocity.
  assign in_ch_raw = in_tdata[6:2];
  assign in_amt    = in_tdata[29:14];
  assign in_ch     = (in_ch_raw < CHAN_MIN) ? CHAN_MIN :
                     (in_ch_raw > CHAN_MAX) ? CHAN_MAX : in_ch_raw;
  assign in_vel    = in_amt[PITCH_W-1] ? '0 : in_amt[VEL_W-1:0];

  assign in_tready  = (st_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign scan_start = accept && ((op_t'(in_tdata[1:0]) == OP_NOTE_ON) ||
                                 (op_t'(in_tdata[1:0]) == OP_NOTE_OFF));
  assign commit     = (st_r == ST_COMMIT) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= op_t'(in_tdata[1:0]);
      ch_r  <= in_ch;
      key_r <= in_tdata[13:7];
      vel_r <= in_vel;
      amt_r <= in_amt;
    end
  end

  // Sequencer: idle, scan the voice table, commit the result.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (accept) begin
          st_nxt = scan_start ? ST_SCAN : ST_COMMIT;
        end
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          st_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Per-channel pitch-wheel lookup for the held channel.
  assign ch_m1     = ch_r - CHAN_W'(1);
  assign pitch_idx = ch_m1[CH_IDX_W-1:0];
  assign ch_pitch  = pitch_r[pitch_idx];

  // Voice chosen by a note-on: match, else lowest free, else oldest.
  assign on_idx = scan_res.match_hit ? scan_res.match_idx :
                  scan_res.free_hit  ? scan_res.free_idx  : scan_res.old_idx;

  // Commit: table write, note state and output register updates.
  always_comb begin
    gate_nxt      = gate_r;
    cur_ch_nxt    = cur_ch_r;
    cur_note_nxt  = cur_note_r;
    cur_vel_nxt   = cur_vel_r;
    cur_pitch_nxt = cur_pitch_r;
    slot_nxt      = slot_r;
    order_nxt     = order_r;
    out_valid_nxt = out_valid_r && !out_tready;
    tbl_clr       = 1'b0;
    tbl_wr.en     = 1'b0;
    tbl_wr.idx    = on_idx;
    tbl_wr.ent    = '{busy: 1'b1, chan: ch_r, key: key_r, age: order_r};
    if (commit) begin
      out_valid_nxt = 1'b1;
      slot_nxt      = SLOT_NONE;
      unique case (op_r)
        OP_NOTE_ON: begin
          tbl_wr.en     = 1'b1;
          slot_nxt      = SLOT_W'(on_idx);
          order_nxt     = (order_r == AGE_MAX) ? order_r : order_r + AGE_W'(1);
          gate_nxt      = 1'b1;
          cur_ch_nxt    = ch_r;
          cur_note_nxt  = {1'b0, key_r};
          cur_vel_nxt   = vel_r;
          cur_pitch_nxt = ch_pitch;
        end
        OP_NOTE_OFF: begin
          tbl_wr.en  = scan_res.match_hit;
          tbl_wr.idx = scan_res.match_idx;
          tbl_wr.ent = '{busy: 1'b0, chan: ch_r, key: key_r, age: '0};
          if (scan_res.match_hit) begin
            slot_nxt = SLOT_W'(scan_res.match_idx);
          end
          if (gate_r && (cur_ch_r == ch_r) && (cur_note_r == {1'b0, key_r})) begin
            gate_nxt      = 1'b0;
            cur_vel_nxt   = '0;
            cur_pitch_nxt = ch_pitch;
          end
        end
        OP_PITCH: begin
          cur_pitch_nxt = amt_r;
        end
        OP_CLEAR: begin
          tbl_clr       = 1'b1;
          order_nxt     = AGE_FIRST;
          gate_nxt      = 1'b0;
          cur_ch_nxt    = CHAN_MIN;
          cur_note_nxt  = NOTE_NONE;
          cur_vel_nxt   = '0;
          cur_pitch_nxt = '0;
        end
        default: out_valid_nxt = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_r      <= 1'b0;
      cur_ch_r    <= CHAN_MIN;
      cur_note_r  <= NOTE_NONE;
      cur_vel_r   <= '0;
      cur_pitch_r <= '0;
      slot_r      <= SLOT_NONE;
      out_valid_r <= 1'b0;
      order_r     <= AGE_FIRST;
    end else begin
      gate_r      <= gate_nxt;
      cur_ch_r    <= cur_ch_nxt;
      cur_note_r  <= cur_note_nxt;
      cur_vel_r   <= cur_vel_nxt;
      cur_pitch_r <= cur_pitch_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
      order_r     <= order_nxt;
    end
  end

  // Pitch-wheel values per channel, cleared by reset and by a clear request.
  always_ff @(posedge clk) begin
    if (!rst_n || (commit && (op_r == OP_CLEAR))) begin
      for (int i = 0; i < CHANNELS; i++) begin
        pitch_r[i] <= '0;
      end
    end else if (commit && (op_r == OP_PITCH)) begin
      pitch_r[pitch_idx] <= amt_r;
    end
  end

  mva_voice_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (tbl_clr),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data),
    .wr      (tbl_wr),
    .act_cnt (act_cnt)
  );

  mva_voice_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scan_start),
    .ch      (ch_r),
    .key     (key_r),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data),
    .res     (scan_res)
  );

  // Result packing; the active count changes only at commit.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, slot_r, SLOT_W'(act_cnt), cur_pitch_r, cur_vel_r,
                       cur_note_r, cur_ch_r, gate_r};

  // A result appears only out of the commit state.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == ST_COMMIT))
    else $error("result raised outside commit");

  // The pool never reports more busy voices than it has.
  assert property (@(posedge clk) disable iff (!rst_n)
    act_cnt <= CNT_W'(VOICES))
    else $error("active voice count exceeds pool size");

  // A held gate always names a real note.
  assert property (@(posedge clk) disable iff (!rst_n)
    gate_r |-> (cur_note_r != NOTE_NONE))
    else $error("gate high without a note");

  // A clear empties the voice pool at once.
  assert property (@(posedge clk) disable iff (!rst_n)
    (commit && (op_r == OP_CLEAR)) |=> (act_cnt == '0) && !gate_r)
    else $error("clear left voices active");

  // A scan is only started from idle, never while a request is in work.
  assert property (@(posedge clk) disable iff (!rst_n)
    scan_start |-> (st_r == ST_IDLE))
    else $error("scan started while busy");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for midi_voice_allocator_core: streams MIDI events in,
// predicts every result with a behavioral voice pool and checks the result stream.
// Depends on mva_pkg and the allocator RTL only.

module tb_top;
  import mva_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_EVENTS  = 900;
  localparam int HOLD_AT_RESULT = 350;
  localparam int HOLD_CYCLES    = 300;
  localparam int PRINT_LIMIT    = 40;

  // One MIDI event request, with the idle cycles the sender spends before it.
  typedef struct {
    op_t                op;
    logic [CHAN_W-1:0]  chan;
    logic [KEY_W-1:0]   key;
    logic [PITCH_W-1:0] amount;
    bit                 drain;
    int                 idle;
  } midi_event_t;

  // Result fields, gate in the lowest bit as on out_tdata.
  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [4:0]         active;
    logic [PITCH_W-1:0] pitch;
    logic [VEL_W-1:0]   vel;
    logic [NOTE_W-1:0]  note;
    logic [CHAN_W-1:0]  chan;
    logic               gate;
  } note_state_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  always #5 clk = ~clk;

  midi_voice_allocator_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Behavioral voice pool.
  logic               pool_busy [VOICES];
  logic [CHAN_W-1:0]  pool_chan [VOICES];
  logic [NOTE_W-1:0]  pool_key  [VOICES];
  logic [VEL_W-1:0]   pool_vel  [VOICES];
  logic [AGE_W-1:0]   pool_age  [VOICES];
  logic [PITCH_W-1:0] wheel     [CHANNELS];
  logic [AGE_W-1:0]   stamp_next;
  note_state_t        cur;

  midi_event_t event_q[$];
  note_state_t note_state_q[$];
  midi_event_t offered;
  logic [11:0] held_q[$];

  bit in_fire = 1'b0;
  bit out_fire = 1'b0;
  bit drain_next = 1'b0;
  bit hold_done = 1'b0;
  int in_gap = 0;
  int out_wait = 0;
  int hold_left = 0;
  int cycles = 0;
  int mismatches = 0;
  int results_seen = 0;
  int events_made = 0;
  int on_count = 0, steal_count = 0, reuse_count = 0;
  int off_hit = 0, off_miss = 0, pitch_count = 0, clear_count = 0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("MISMATCH %s", msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                results_seen, name, got, want));
  endtask

  // Return the pool and the current note state to their reset contents.
  task automatic clear_voice_pool();
    for (int i = 0; i < VOICES; i++) begin
      pool_busy[i] = 1'b0;
      pool_chan[i] = CHAN_MIN;
      pool_key[i]  = NOTE_NONE;
      pool_vel[i]  = '0;
      pool_age[i]  = '0;
    end
    for (int c = 0; c < CHANNELS; c++) wheel[c] = '0;
    stamp_next = AGE_FIRST;
    cur        = '0;
    cur.chan   = CHAN_MIN;
    cur.note   = NOTE_NONE;
  endtask

  // Apply one accepted event to the pool and produce the result it causes.
  task automatic apply_midi_event(input midi_event_t ev, output note_state_t res);
    int                ch;
    int                hit;
    int                pick;
    int                n;
    logic [VEL_W-1:0]  vel;
    logic [NOTE_W-1:0] key;
    begin
      ch = int'(ev.chan);
      if (ch < 1) ch = 1;
      if (ch > CHANNELS) ch = CHANNELS;
      key  = {1'b0, ev.key};
      hit  = -1;
      pick = -1;
      for (int i = VOICES - 1; i >= 0; i--)
        if (pool_busy[i] && pool_chan[i] == CHAN_W'(ch) && pool_key[i] == key) hit = i;

      case (ev.op)
        OP_NOTE_ON: begin
          on_count++;
          vel = ev.amount[PITCH_W-1] ? '0 : ev.amount[VEL_W-1:0];
          pick = hit;
          if (pick >= 0) reuse_count++;
          // Lowest free voice first, else the oldest stamp, lowest index on ties.
          if (pick < 0)
            for (int i = VOICES - 1; i >= 0; i--) if (!pool_busy[i]) pick = i;
          if (pick < 0) begin
            pick = 0;
            for (int i = 1; i < VOICES; i++) if (pool_age[i] < pool_age[pick]) pick = i;
            steal_count++;
          end
          pool_busy[pick] = 1'b1;
          pool_chan[pick] = CHAN_W'(ch);
          pool_key[pick]  = key;
          pool_vel[pick]  = vel;
          pool_age[pick]  = stamp_next;
          if (stamp_next != AGE_MAX) stamp_next++;
          cur.gate  = 1'b1;
          cur.chan  = CHAN_W'(ch);
          cur.note  = key;
          cur.vel   = vel;
          cur.pitch = wheel[ch-1];
        end
        OP_NOTE_OFF: begin
          pick = hit;
          if (hit >= 0) begin
            off_hit++;
            pool_busy[hit] = 1'b0;
            pool_vel[hit]  = '0;
            pool_age[hit]  = '0;
          end else begin
            off_miss++;
          end
          // The gate only drops when the event names the current note.
          if (cur.gate && cur.chan == CHAN_W'(ch) && cur.note == key) begin
            cur.gate  = 1'b0;
            cur.vel   = '0;
            cur.pitch = wheel[ch-1];
          end
        end
        OP_PITCH: begin
          pitch_count++;
          wheel[ch-1] = ev.amount;
          cur.pitch   = ev.amount;
        end
        default: begin
          clear_count++;
          clear_voice_pool();
        end
      endcase

      n = 0;
      for (int i = 0; i < VOICES; i++) n += pool_busy[i] ? 1 : 0;
      res        = cur;
      res.active = 5'(n);
      res.slot   = (pick < 0) ? SLOT_NONE : SLOT_W'(pick);
    end
  endtask

  task automatic push_event(input op_t op, input int chan, input int key,
                            input int amount, input bit quick);
    midi_event_t e;
    begin
      e.op     = op;
      e.chan   = CHAN_W'(chan);
      e.key    = KEY_W'(key);
      e.amount = PITCH_W'(amount);
      e.drain  = drain_next;
      e.idle   = quick ? 0 : $urandom_range(0, 8);
      drain_next = 1'b0;
      event_q.push_back(e);
      events_made++;
    end
  endtask

  // One random event; kind 0 builds chords, 1 and 2 mix, 3 is noise.
  task automatic add_random_event(input int kind, input bit quick);
    int   roll;
    int   ch;
    int   key;
    int   vel;
    int   idx;
    begin
      roll = $urandom_range(0, 99);
      ch   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
      key  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(48, 71);
      vel  = ($urandom_range(0, 9) == 0) ? int'($urandom()) : $urandom_range(1, 32767);
      if (kind == 3) begin
        if (roll < 3) push_event(OP_CLEAR, $urandom_range(0, 31), $urandom_range(0, 127),
                                 int'($urandom()), quick);
        else push_event(op_t'($urandom_range(0, 2)), $urandom_range(0, 31),
                        $urandom_range(0, 127), int'($urandom()), quick);
      end else if (roll < ((kind == 0) ? 70 : 45)) begin
        push_event(OP_NOTE_ON, ch, key, vel, quick);
        held_q.push_back({5'(ch), 7'(key)});
        if (held_q.size() > 24) void'(held_q.pop_front());
      end else if (roll < ((kind == 0) ? 90 : 85)) begin
        // Mostly release a note that was played, sometimes a stray one.
        if (held_q.size() > 0 && $urandom_range(0, 9) < 8) begin
          idx = $urandom_range(0, held_q.size() - 1);
          push_event(OP_NOTE_OFF, int'(held_q[idx][11:7]), int'(held_q[idx][6:0]), vel, quick);
          held_q.delete(idx);
        end else begin
          push_event(OP_NOTE_OFF, ch, key, vel, quick);
        end
      end else begin
        push_event(OP_PITCH, ch, key, int'($urandom()), quick);
      end
    end
  endtask

  // Sample both handshakes; predict on each accepted request, check each result.
  always @(posedge clk) begin
    note_state_t want;
    note_state_t got;
    in_fire  <= rst_n && in_tvalid && in_tready;
    out_fire <= rst_n && out_tvalid && out_tready;
    if (!rst_n) clear_voice_pool();
    if (rst_n && out_tvalid && out_tready) begin
      got = note_state_t'(out_tdata[$bits(note_state_t)-1:0]);
      if (note_state_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = note_state_q.pop_front();
        check_field("gate", int'(got.gate), int'(want.gate));
        check_field("channel_now", int'(got.chan), int'(want.chan));
        check_field("note_now", int'(got.note), int'(want.note));
        check_field("velocity_now", int'(got.vel), int'(want.vel));
        check_field("pitch_now", int'(got.pitch), int'(want.pitch));
        check_field("active_voices", int'(got.active), int'(want.active));
        check_field("voice_slot", int'(got.slot), int'(want.slot));
      end
      results_seen++;
    end
    if (rst_n && in_tvalid && in_tready) begin
      apply_midi_event(offered, want);
      note_state_q.push_back(want);
    end
  end

  // Sender: waits each event's idle cycles, and for a drain point waits until
  // every expected result has come back.
  always @(negedge clk) begin
    bit v;
    v = in_tvalid;
    if (in_fire) v = 1'b0;
    if (rst_n && !v) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (event_q.size() > 0 && !(event_q[0].drain && note_state_q.size() > 0)) begin
        offered = event_q.pop_front();
        in_tdata <= {2'b00, offered.amount, offered.key, offered.chan, offered.op};
        v = 1'b1;
        in_gap = (event_q.size() > 0) ? event_q[0].idle : 0;
      end
    end
    in_tvalid <= v;
  end

  // Receiver: random wait per result, one long hold-off partway through.
  always @(negedge clk) begin
    bit r;
    r = out_tready;
    if (!rst_n) begin
      r = 1'b0;
    end else if (out_fire) begin
      if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end else begin
        out_wait = ((results_seen % 200) < 50) ? 0 : $urandom_range(0, 8);
      end
      r = (out_wait == 0 && hold_left == 0);
    end else if (hold_left > 0) begin
      hold_left--;
      r = (hold_left == 0);
    end else if (out_wait > 0) begin
      out_wait--;
      r = (out_wait == 0);
    end else begin
      r = 1'b1;
    end
    out_tready <= r;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int kind;
    int seg_len;
    bit quick;
    rst_n      = 1'b0;

    // Directed events: field extremes, clamping, reuse, gate rules, clear.
    push_event(OP_NOTE_ON, 1, 60, 16384, 1'b0);
    push_event(OP_NOTE_ON, 0, 0, 32767, 1'b0);        // channel 0 clamps to 1
    push_event(OP_NOTE_ON, 31, 127, -32768, 1'b0);    // high channel, negative velocity
    push_event(OP_PITCH, 31, 0, 32767, 1'b0);
    push_event(OP_PITCH, 0, 127, -32768, 1'b0);
    push_event(OP_NOTE_ON, 16, 127, 100, 1'b0);       // same voice reused
    push_event(OP_NOTE_OFF, 1, 60, 0, 1'b0);          // not the current note
    push_event(OP_NOTE_OFF, 1, 60, 0, 1'b0);          // no voice holds it
    push_event(OP_NOTE_OFF, 16, 127, 0, 1'b0);        // current note, gate drops
    push_event(OP_NOTE_ON, 5, 85, 16'h5555, 1'b0);
    push_event(OP_NOTE_ON, 10, 42, 16'h2AAA, 1'b0);
    push_event(OP_PITCH, 10, 85, 16'h5555, 1'b0);
    push_event(OP_PITCH, 5, 42, -21846, 1'b0);
    push_event(OP_NOTE_OFF, 17, 42, 0, 1'b0);         // clamps to 16, no match
    push_event(OP_NOTE_OFF, 10, 42, 0, 1'b0);
    push_event(OP_NOTE_ON, 2, 1, 0, 1'b0);            // zero velocity still gates
    push_event(OP_CLEAR, 21, 106, 16'hFFFF, 1'b0);
    push_event(OP_NOTE_OFF, 1, 0, 0, 1'b0);           // after clear, nothing held
    push_event(OP_PITCH, 8, 3, 1, 1'b0);
    push_event(OP_NOTE_ON, 8, 127, 32767, 1'b0);      // picks up the channel's wheel
    push_event(OP_CLEAR, 0, 0, 0, 1'b0);

    // Random segments; up to two drain points make the sender wait for the pipe to empty.
    while (events_made < RANDOM_EVENTS + 21) begin
      kind    = $urandom_range(0, 4);
      if (kind == 4) kind = 0;
      seg_len = $urandom_range(30, 80);
      quick   = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < seg_len; k++) begin
        if (events_made == 320 || events_made == 640) drain_next = 1'b1;
        add_random_event(kind, quick);
      end
      if ($urandom_range(0, 2) == 0) begin
        push_event(OP_CLEAR, $urandom_range(0, 31), $urandom_range(0, 127),
                   int'($urandom()), quick);
        held_q.delete();
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (event_q.size() > 0 || in_tvalid || note_state_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (note_state_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", note_state_q.size()));

    $display("Covered %0d note-ons (%0d reused, %0d stolen), %0d note-offs (%0d unmatched),",
             on_count, reuse_count, steal_count, off_hit + off_miss, off_miss);
    $display("%0d pitch-wheel and %0d clear events; %0d results checked in %0d cycles.",
             pitch_count, clear_count, results_seen, cycles);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/mva_pkg.sv
rtl/core/mva_voice_table.sv
rtl/core/mva_voice_scan.sv
rtl/core/midi_voice_allocator_core.sv
tb/tb_top.sv
